/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file s2d_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/s2d_pkg.sv */
`default_nettype none
package s2d_pkg;

  // Width of the signed input value
  localparam int VALUE_WIDTH = 32;
  // Input tdata width, padded up to whole bytes
  localparam int IN_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
  // Decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  // Counter widths
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  localparam int CHAR_WIDTH = 8;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

  // Double-dabble correction: add three to a digit of five or more
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef logic [3:0] digit_t;

  // Control common to every digit cell
  typedef struct packed {
    logic clear;    // zero the digit
    logic convert;  // adjust and shift in one binary bit
    logic rotate;   // take the lower neighbor's digit
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Signed integer to decimal ASCII text.
// Input: one transaction on s_* carries a signed value in s_tdata (two's
// complement). Output: one transaction per character on m_*, most
// significant first; '-' leads a negative value, m_tlast marks the final
// digit. Zero gives the single character '0'.
// Conversion runs in a row of BCD digit cells (shift-and-add-3): one
// binary bit enters per cycle; the cells then shift their digits toward
// the top cell, one per cycle while the receiver does not stall, dropping
// leading zeros and emitting the rest.
// s_tready is high only while idle; the next item is taken while the
// final character still waits in the output register.
// A receiver stall holds the output register and pauses the digit scan.
// Reset (rst, synchronous) drops any item in flight and empties the
// output register.
`default_nettype none
module signed_int_to_decimal_ascii (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [s2d_pkg::IN_DATA_WIDTH-1:0]    s_tdata,   // [31:0] value
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [s2d_pkg::CHAR_WIDTH-1:0]      m_tdata,   // [7:0] character
  output logic                                m_tlast    // last
);

  localparam int W  = s2d_pkg::VALUE_WIDTH;
  localparam int ND = s2d_pkg::NUM_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [W-1:0]                   mag;
  logic                           neg;
  logic [s2d_pkg::BIT_CNT_W-1:0]  bit_cnt;
  logic [s2d_pkg::DIG_CNT_W-1:0]  remain;

  logic [W-1:0]                   raw;
  logic [W-1:0]                   in_mag;
  logic                           in_accept;
  logic                           out_free;
  logic                           load_out;
  logic                           last_digit;
  s2d_pkg::cell_ctrl_t            ctrl;
  s2d_pkg::digit_t                top_digit;

  logic               carry [ND+1];
  s2d_pkg::digit_t    digits [ND+1];

  // Input magnitude, unsigned so the most negative value is exact
  assign raw       = s_tdata[W-1:0];
  assign in_mag    = raw[W-1] ? W'(~raw + W'(1)) : raw;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign top_digit = digits[ND];

  // Output register loads a sign or a digit
  assign load_out   = ((state == S_SIGN) || (state == S_EMIT)) && out_free;
  assign last_digit = (remain == s2d_pkg::DIG_CNT_W'(1));

  // Cell control
  always_comb begin
    ctrl.clear   = in_accept;
    ctrl.convert = (state == S_CONV);
    ctrl.rotate  = ((state == S_SKIP) && (top_digit == '0) && !last_digit) ||
                   ((state == S_EMIT) && out_free);
  end

  // Row of digit cells; cell 0 takes the next magnitude bit
  assign carry[0]  = mag[W-1];
  assign digits[0] = '0;

  for (genvar i = 0; i < ND; i++) begin : g_cell
    s2d_bcd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (carry[i]),
      .digit_in (digits[i]),
      .bit_out  (carry[i+1]),
      .digit    (digits[i+1])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      bit_cnt  <= '0;
      remain   <= '0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            mag     <= in_mag;
            neg     <= raw[W-1];
            bit_cnt <= '0;
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          mag     <= mag << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == s2d_pkg::BIT_CNT_W'(W - 1)) begin
            remain <= s2d_pkg::DIG_CNT_W'(ND);
            state  <= neg ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            m_tdata  <= s2d_pkg::CHAR_MINUS;
            m_tlast  <= 1'b0;
            state    <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (ctrl.rotate) begin
            remain <= remain - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= s2d_pkg::CHAR_ZERO + s2d_pkg::CHAR_WIDTH'(top_digit);
            m_tlast  <= last_digit;
            remain   <= remain - 1'b1;
            if (last_digit) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/s2d_bcd_cell.sv */
`default_nettype none
module s2d_bcd_cell (
  input  wire                 clk,
  input  s2d_pkg::cell_ctrl_t ctrl,
  input  wire                 bit_in,    // binary bit from lower cell
  input  s2d_pkg::digit_t     digit_in,  // digit of lower cell
  output logic                bit_out,   // carry to upper cell
  output s2d_pkg::digit_t     digit
);

  s2d_pkg::digit_t adj;
  s2d_pkg::digit_t digit_next;

  // Add-three correction before the shift
  always_comb begin
    adj = (digit >= s2d_pkg::BCD_ADJ_MIN) ? digit + s2d_pkg::BCD_ADJ : digit;
  end

  assign bit_out = adj[3];

  always_comb begin
    digit_next = digit;
    if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.convert) begin
      digit_next = {adj[2:0], bit_in};
    end else if (ctrl.rotate) begin
      digit_next = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule
`default_nettype wire

/* rtl/core/s2d_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module s2d_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [s2d_pkg::CHAR_WIDTH-1:0]    m_tdata,
  input wire                              m_tlast
);

  logic                          in_xfer;
  logic                          stall;
  logic                          is_minus;
  logic                          is_digit;
  logic [s2d_pkg::CHAR_WIDTH:0]  out_word;

  assign in_xfer  = s_tvalid && s_tready;
  assign stall    = m_tvalid && !m_tready;
  assign is_minus = (m_tdata == s2d_pkg::CHAR_MINUS);
  assign is_digit = (m_tdata >= s2d_pkg::CHAR_ZERO) && (m_tdata <= s2d_pkg::CHAR_NINE);
  assign out_word = {m_tlast, m_tdata};

  // Stalled output transaction holds its payload
  `ASSERT_CLK(a_out_hold, stall |=> m_tvalid && $stable(out_word), "stalled output changed")

  // Only a minus sign or a decimal digit is ever sent
  `ASSERT_CLK(a_char_set, m_tvalid |-> is_minus || is_digit, "bad character")

  // A sign is never the end of the text
  `ASSERT_CLK(a_minus_not_last, m_tvalid && is_minus |-> !m_tlast, "minus marked last")

  // A new item starts only after the previous text is complete
  `ASSERT_CLK(a_accept_after_last, in_xfer |-> !m_tvalid || m_tlast, "input taken mid-text")

  // Output register is empty right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid after reset")

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
